>>> rtl/sesp_pkg.sv
// sesp_pkg: shared types, phase codes, request codes and constants of the
// sector erase / program sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sesp_pkg;

   // field widths
   localparam int AddrW     = 32;
   localparam int ByteW     = 8;
   localparam int KindW     = 3;
   localparam int WaitW     = 7;
   localparam int OutcomeW  = 2;
   localparam int PhaseW    = 5;
   localparam int AttemptW  = 3;
   localparam int PollW     = 9;
   localparam int PrefixW   = 3;
   localparam int PageBytesW = 13;

   localparam logic [PageBytesW-1:0] PageBytesReset = 13'd128;
   localparam int MaxPageBytesDefault = 4096;
   localparam int PageBytesCap = (1 << PageBytesW) - 1;

   // input op codes
   localparam logic OpStart    = 1'b0;
   localparam logic OpResponse = 1'b1;

   // request kinds
   localparam logic [KindW-1:0] KindRead  = 3'd0;
   localparam logic [KindW-1:0] KindWrite = 3'd1;
   localparam logic [KindW-1:0] KindWait  = 3'd2;
   localparam logic [KindW-1:0] KindFetch = 3'd3;
   localparam logic [KindW-1:0] KindDone  = 3'd4;

   // outcomes
   localparam logic [OutcomeW-1:0] OutOk      = 2'd0;
   localparam logic [OutcomeW-1:0] OutProgram = 2'd1;
   localparam logic [OutcomeW-1:0] OutErase   = 2'd2;

   // sequencer phases
   localparam logic [PhaseW-1:0] PhIdle          = 5'd0;
   localparam logic [PhaseW-1:0] PhUnprot        = 5'd1;
   localparam logic [PhaseW-1:0] PhEraseCmd1     = 5'd2;
   localparam logic [PhaseW-1:0] PhEraseCmd2     = 5'd3;
   localparam logic [PhaseW-1:0] PhEraseRead     = 5'd4;
   localparam logic [PhaseW-1:0] PhEraseWaitMore = 5'd5;
   localparam logic [PhaseW-1:0] PhEraseWaitPass = 5'd6;
   localparam logic [PhaseW-1:0] PhEraseWaitFail = 5'd7;
   localparam logic [PhaseW-1:0] PhBlankRead     = 5'd8;
   localparam logic [PhaseW-1:0] PhFetch         = 5'd9;
   localparam logic [PhaseW-1:0] PhProgCmd       = 5'd10;
   localparam logic [PhaseW-1:0] PhProgData      = 5'd11;
   localparam logic [PhaseW-1:0] PhProgRead      = 5'd12;
   localparam logic [PhaseW-1:0] PhProgWaitMore  = 5'd13;
   localparam logic [PhaseW-1:0] PhProgWaitDone  = 5'd14;
   localparam logic [PhaseW-1:0] PhProgCheck     = 5'd15;
   localparam logic [PhaseW-1:0] PhResetWrite    = 5'd16;
   localparam logic [PhaseW-1:0] PhProtect       = 5'd17;

   // flash command bytes and timing
   localparam logic [ByteW-1:0] CmdEraseSetup   = 8'h20;
   localparam logic [ByteW-1:0] CmdEraseConfirm = 8'hD0;
   localparam logic [ByteW-1:0] CmdProgram      = 8'h10;
   localparam logic [ByteW-1:0] CmdReset        = 8'hFF;
   localparam logic [ByteW-1:0] BlankByte       = 8'hFF;
   localparam logic [PollW-1:0] ErasePolls      = 9'd500;
   localparam logic [PollW-1:0] ProgPolls       = 9'd60;
   localparam logic [WaitW-1:0] EraseWaitUs     = 7'd100;
   localparam logic [WaitW-1:0] ProgWaitUs      = 7'd1;
   localparam logic [AttemptW-1:0] MaxAttempts  = 3'd4;
   localparam logic [AddrW-1:0] StatusOffset    = 32'd127;
   localparam logic [AddrW-1:0] UnlockLast      = 32'h0000_041A;
   localparam logic [AddrW-1:0] LockLast        = 32'h0000_040A;
   localparam logic [PrefixW-1:0] PrefixLen     = 3'd6;

   typedef struct packed {
      logic              op;
      logic [AddrW-1:0]  sector_offset;
      logic [AddrW-1:0]  source_base;
      logic [ByteW-1:0]  response_byte;
      logic              response_ok;
   } item_type;

   typedef struct packed {
      logic [KindW-1:0]    request_kind;
      logic [AddrW-1:0]    request_address;
      logic [ByteW-1:0]    write_byte;
      logic [WaitW-1:0]    wait_micros;
      logic [OutcomeW-1:0] outcome;
   } result_type;

   // sequencer state, byte index kept apart since its width is parameterized
   typedef struct packed {
      logic [PhaseW-1:0]   phase;
      logic [AttemptW-1:0] attempt_count;
      logic [PollW-1:0]    poll_budget;
      logic [PrefixW-1:0]  prefix_step;
      logic [ByteW-1:0]    data_byte;
      logic [AddrW-1:0]    sector_base;
      logic [AddrW-1:0]    source_start;
      logic [OutcomeW-1:0] pending_outcome;
   } state_type;

   localparam state_type StateReset = '{
      phase: PhIdle, attempt_count: '0, poll_budget: '0, prefix_step: '0,
      data_byte: '0, sector_base: '0, source_start: '0, pending_outcome: OutOk
   };

   // lock / unlock read address for a prefix step
   function automatic logic [AddrW-1:0] lock_addr(input logic [PrefixW-1:0] step,
                                                   input logic [AddrW-1:0] last);
      logic [AddrW-1:0] a;
      case (step)
         3'd0:    a = 32'h0000_1823;
         3'd1:    a = 32'h0000_1820;
         3'd2:    a = 32'h0000_1822;
         3'd3:    a = 32'h0000_0418;
         3'd4:    a = 32'h0000_041B;
         3'd5:    a = 32'h0000_0419;
         default: a = last;
      endcase
      return a;
   endfunction

   function automatic result_type make_req(input logic [KindW-1:0] kind,
                                           input logic [AddrW-1:0] addr,
                                           input logic [ByteW-1:0] wb,
                                           input logic [WaitW-1:0] wt,
                                           input logic [OutcomeW-1:0] oc);
      result_type r;
      r.request_kind    = kind;
      r.request_address = addr;
      r.write_byte      = wb;
      r.wait_micros     = wt;
      r.outcome         = oc;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sesp_in_reg.sv
// sesp_in_reg: input register of the sequencer, holds one request-side beat
// until the step logic takes it. Depends on sesp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sesp_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sesp_pkg::item_type req_item,
   input  wire logic              advance,
   output logic                   item_valid,
   output sesp_pkg::item_type     item
);

   logic               valid_ff;
   logic               valid_in;
   sesp_pkg::item_type item_ff;
   logic               take;

   assign req_stall = valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> rtl/sesp_step.sv
// sesp_step: combinational next-state and request logic for one beat of the
// sector erase / program sequence. Depends on sesp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sesp_step #(
   parameter int MAX_PAGE_BYTES = sesp_pkg::MaxPageBytesDefault,
   parameter int IDX_W          = sesp_pkg::PageBytesW
) (
   input  wire sesp_pkg::item_type                 item,
   input  wire sesp_pkg::state_type                st,
   input  wire logic [IDX_W-1:0]                   byte_index,
   input  wire logic [sesp_pkg::PageBytesW-1:0]    page_bytes,
   output sesp_pkg::state_type                     st_next,
   output logic [IDX_W-1:0]                        byte_index_next,
   output sesp_pkg::result_type                    result
);

   logic [IDX_W-1:0]                 page_len;
   logic [IDX_W-1:0]                 idx_inc;
   logic [IDX_W-1:0]                 fetch_idx;
   logic [sesp_pkg::AddrW-1:0]       here;
   logic [sesp_pkg::AddrW-1:0]       status_addr;
   logic [sesp_pkg::PollW-1:0]       poll_dec;
   logic [sesp_pkg::AttemptW-1:0]    attempt_inc;
   logic [sesp_pkg::PrefixW-1:0]     prefix_inc;
   logic [sesp_pkg::OutcomeW-1:0]    code;
   logic                             go_fetch;
   logic                             go_protect;
   logic                             go_reset;
   logic                             go_finish;
   logic                             ok;
   logic [sesp_pkg::ByteW-1:0]       rb;

   // sector size, clipped to the largest supported page
   always_comb begin
      if (32'(page_bytes) > 32'(MAX_PAGE_BYTES)) begin
         page_len = IDX_W'(MAX_PAGE_BYTES);
      end else begin
         page_len = page_bytes[IDX_W-1:0];
      end
   end

   assign ok          = item.response_ok;
   assign rb          = item.response_byte;
   assign idx_inc     = byte_index + 1'b1;
   assign here        = st.sector_base + sesp_pkg::AddrW'(byte_index);
   assign status_addr = st.sector_base + sesp_pkg::StatusOffset;
   assign poll_dec    = (st.poll_budget != '0) ? st.poll_budget - 1'b1 : st.poll_budget;
   assign attempt_inc = st.attempt_count + 1'b1;
   assign prefix_inc  = st.prefix_step + 1'b1;

   always_comb begin
      st_next         = st;
      byte_index_next = byte_index;
      result          = '0;
      go_fetch        = 1'b0;
      go_protect      = 1'b0;
      go_reset        = 1'b0;
      go_finish       = 1'b0;
      code            = sesp_pkg::OutOk;
      fetch_idx       = byte_index;

      if (item.op == sesp_pkg::OpStart) begin
         st_next.sector_base     = item.sector_offset;
         st_next.source_start    = item.source_base;
         st_next.attempt_count   = '0;
         st_next.poll_budget     = '0;
         st_next.data_byte       = '0;
         st_next.pending_outcome = sesp_pkg::OutOk;
         st_next.prefix_step     = '0;
         st_next.phase           = sesp_pkg::PhUnprot;
         byte_index_next         = '0;
         result = sesp_pkg::make_req(sesp_pkg::KindRead,
                     sesp_pkg::lock_addr('0, sesp_pkg::UnlockLast), '0, '0, '0);
      end else begin
         case (st.phase)
            sesp_pkg::PhUnprot: begin
               if (!ok) begin
                  go_finish = 1'b1;
                  code      = sesp_pkg::OutProgram;
               end else if (st.prefix_step < sesp_pkg::PrefixLen) begin
                  st_next.prefix_step = prefix_inc;
                  result = sesp_pkg::make_req(sesp_pkg::KindRead,
                     sesp_pkg::lock_addr(prefix_inc, sesp_pkg::UnlockLast), '0, '0, '0);
               end else begin
                  st_next.phase = sesp_pkg::PhEraseCmd1;
                  result = sesp_pkg::make_req(sesp_pkg::KindWrite, '0,
                     sesp_pkg::CmdEraseSetup, '0, '0);
               end
            end
            sesp_pkg::PhEraseCmd1: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutErase;
               end else begin
                  st_next.phase = sesp_pkg::PhEraseCmd2;
                  result = sesp_pkg::make_req(sesp_pkg::KindWrite, st.sector_base,
                     sesp_pkg::CmdEraseConfirm, '0, '0);
               end
            end
            sesp_pkg::PhEraseCmd2: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutErase;
               end else begin
                  st_next.poll_budget = sesp_pkg::ErasePolls;
                  st_next.phase       = sesp_pkg::PhEraseRead;
                  result = sesp_pkg::make_req(sesp_pkg::KindRead, status_addr, '0, '0, '0);
               end
            end
            sesp_pkg::PhEraseRead: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutErase;
               end else begin
                  st_next.poll_budget = poll_dec;
                  // bit 7 done, bit 5 timeout flag of the part
                  if (!rb[7] && !rb[5] && poll_dec != '0) begin
                     st_next.phase = sesp_pkg::PhEraseWaitMore;
                  end else if (rb[7] && !rb[5]) begin
                     st_next.phase = sesp_pkg::PhEraseWaitPass;
                  end else begin
                     st_next.phase = sesp_pkg::PhEraseWaitFail;
                  end
                  result = sesp_pkg::make_req(sesp_pkg::KindWait, '0, '0,
                     sesp_pkg::EraseWaitUs, '0);
               end
            end
            sesp_pkg::PhEraseWaitMore, sesp_pkg::PhEraseWaitPass,
            sesp_pkg::PhEraseWaitFail: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutErase;
               end else if (st.phase == sesp_pkg::PhEraseWaitMore) begin
                  st_next.phase = sesp_pkg::PhEraseRead;
                  result = sesp_pkg::make_req(sesp_pkg::KindRead, status_addr, '0, '0, '0);
               end else if (st.phase == sesp_pkg::PhEraseWaitFail) begin
                  go_reset = 1'b1;
                  code     = sesp_pkg::OutErase;
               end else begin
                  byte_index_next = '0;
                  if (page_len == '0) begin
                     go_protect = 1'b1;
                     code       = sesp_pkg::OutOk;
                  end else begin
                     st_next.phase = sesp_pkg::PhBlankRead;
                     result = sesp_pkg::make_req(sesp_pkg::KindRead, st.sector_base,
                        '0, '0, '0);
                  end
               end
            end
            sesp_pkg::PhBlankRead: begin
               if (!ok || rb != sesp_pkg::BlankByte) begin
                  go_reset = 1'b1;
                  code     = sesp_pkg::OutErase;
               end else if (idx_inc < page_len) begin
                  byte_index_next = idx_inc;
                  result = sesp_pkg::make_req(sesp_pkg::KindRead,
                     st.sector_base + sesp_pkg::AddrW'(idx_inc), '0, '0, '0);
               end else begin
                  byte_index_next = '0;
                  go_fetch        = 1'b1;
                  fetch_idx       = '0;
               end
            end
            sesp_pkg::PhFetch: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutProgram;
               end else begin
                  st_next.data_byte     = rb;
                  st_next.attempt_count = '0;
                  st_next.phase         = sesp_pkg::PhProgCmd;
                  result = sesp_pkg::make_req(sesp_pkg::KindWrite, '0,
                     sesp_pkg::CmdProgram, '0, '0);
               end
            end
            sesp_pkg::PhProgCmd: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutProgram;
               end else begin
                  st_next.phase = sesp_pkg::PhProgData;
                  result = sesp_pkg::make_req(sesp_pkg::KindWrite, here, st.data_byte,
                     '0, '0);
               end
            end
            sesp_pkg::PhProgData: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutProgram;
               end else begin
                  st_next.poll_budget = sesp_pkg::ProgPolls;
                  st_next.phase       = sesp_pkg::PhProgRead;
                  result = sesp_pkg::make_req(sesp_pkg::KindRead, here, '0, '0, '0);
               end
            end
            sesp_pkg::PhProgRead: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutProgram;
               end else begin
                  st_next.poll_budget = poll_dec;
                  // data polling: bit 7 follows the data once the write lands
                  if (rb[7] != st.data_byte[7] && !rb[5] && poll_dec != '0) begin
                     st_next.phase = sesp_pkg::PhProgWaitMore;
                  end else begin
                     st_next.phase = sesp_pkg::PhProgWaitDone;
                  end
                  result = sesp_pkg::make_req(sesp_pkg::KindWait, '0, '0,
                     sesp_pkg::ProgWaitUs, '0);
               end
            end
            sesp_pkg::PhProgWaitMore, sesp_pkg::PhProgWaitDone: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutProgram;
               end else begin
                  st_next.phase = (st.phase == sesp_pkg::PhProgWaitMore) ?
                     sesp_pkg::PhProgRead : sesp_pkg::PhProgCheck;
                  result = sesp_pkg::make_req(sesp_pkg::KindRead, here, '0, '0, '0);
               end
            end
            sesp_pkg::PhProgCheck: begin
               if (!ok) begin
                  go_protect = 1'b1;
                  code       = sesp_pkg::OutProgram;
               end else if (rb[7] == st.data_byte[7] && !rb[5]) begin
                  byte_index_next = idx_inc;
                  go_fetch        = 1'b1;
                  fetch_idx       = idx_inc;
               end else begin
                  st_next.attempt_count = attempt_inc;
                  if (attempt_inc >= sesp_pkg::MaxAttempts) begin
                     go_reset = 1'b1;
                     code     = sesp_pkg::OutProgram;
                  end else begin
                     st_next.phase = sesp_pkg::PhProgCmd;
                     result = sesp_pkg::make_req(sesp_pkg::KindWrite, '0,
                        sesp_pkg::CmdProgram, '0, '0);
                  end
               end
            end
            sesp_pkg::PhResetWrite: begin
               // response to the reset write is ignored
               go_protect = 1'b1;
               code       = st.pending_outcome;
            end
            sesp_pkg::PhProtect: begin
               if (!ok) begin
                  go_finish = 1'b1;
                  code      = sesp_pkg::OutProgram;
               end else if (st.prefix_step < sesp_pkg::PrefixLen) begin
                  st_next.prefix_step = prefix_inc;
                  result = sesp_pkg::make_req(sesp_pkg::KindRead,
                     sesp_pkg::lock_addr(prefix_inc, sesp_pkg::LockLast), '0, '0, '0);
               end else begin
                  go_finish = 1'b1;
                  code      = st.pending_outcome;
               end
            end
            default: begin
               // response with no job running
               go_finish = 1'b1;
               code      = sesp_pkg::OutProgram;
            end
         endcase

         // next byte fetch, or protect once the sector is done
         if (go_fetch) begin
            if (fetch_idx >= page_len) begin
               go_protect = 1'b1;
               code       = sesp_pkg::OutOk;
            end else begin
               st_next.phase = sesp_pkg::PhFetch;
               result = sesp_pkg::make_req(sesp_pkg::KindFetch,
                  st.source_start + sesp_pkg::AddrW'(fetch_idx), '0, '0, '0);
            end
         end

         if (go_protect) begin
            st_next.pending_outcome = code;
            st_next.prefix_step     = '0;
            st_next.phase           = sesp_pkg::PhProtect;
            result = sesp_pkg::make_req(sesp_pkg::KindRead,
               sesp_pkg::lock_addr('0, sesp_pkg::LockLast), '0, '0, '0);
         end

         if (go_reset) begin
            st_next.pending_outcome = code;
            st_next.phase           = sesp_pkg::PhResetWrite;
            result = sesp_pkg::make_req(sesp_pkg::KindWrite, '0, sesp_pkg::CmdReset,
               '0, '0);
         end

         if (go_finish) begin
            st_next.phase = sesp_pkg::PhIdle;
            result = sesp_pkg::make_req(sesp_pkg::KindDone, '0, '0, '0, code);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/sesp_out_reg.sv
// sesp_out_reg: result register of the sequencer, holds one request beat
// until the receiver takes it. Depends on sesp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sesp_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire sesp_pkg::result_type result,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output sesp_pkg::result_type      rsp_result,
   output logic                      can_load
);

   logic                 valid_ff;
   logic                 valid_in;
   sesp_pkg::result_type result_ff;

   assign can_load = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

>>> rtl/sector_erase_program_sequencer_top.sv
// sector_erase_program_sequencer_top: top level of the sector erase / program
// sequencer. Depends on sesp_pkg, sesp_in_reg, sesp_step and sesp_out_reg.
//
// usage
//  - a req beat with op start names a sector offset and a source address;
//    every later req beat (op response) carries the byte and ok flag that
//    answer the previous request
//  - each req beat yields exactly one rsp beat: flash read, flash write,
//    wait, source fetch, or finished with an outcome code
//  - csr_write_enable / csr_write_data set the sector size in bytes; write
//    it only while no beat is in flight
//  - path: an accepted req beat is held in the input register; its rsp beat
//    is registered in the result register
//  - throughput: one beat per cycle while rsp_stall is low; the step logic
//    is one pass from input register via sequencer registers to result reg
//  - rsp_stall holds the result register; the input register then holds its
//    beat and req_stall rises, so nothing is dropped or repeated
//  - reset: both registers empty, sequencer idle, sector size 128 bytes
`timescale 1ns / 1ps
`default_nettype none

module sector_erase_program_sequencer_top #(
   parameter int MAX_PAGE_BYTES = sesp_pkg::MaxPageBytesDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request-side beats
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_op,
   input  wire logic [sesp_pkg::AddrW-1:0]         req_sector_offset,
   input  wire logic [sesp_pkg::AddrW-1:0]         req_source_base,
   input  wire logic [sesp_pkg::ByteW-1:0]         req_response_byte,
   input  wire logic                               req_response_ok,
   // result beats
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [sesp_pkg::KindW-1:0]              rsp_request_kind,
   output logic [sesp_pkg::AddrW-1:0]              rsp_request_address,
   output logic [sesp_pkg::ByteW-1:0]              rsp_write_byte,
   output logic [sesp_pkg::WaitW-1:0]              rsp_wait_micros,
   output logic [sesp_pkg::OutcomeW-1:0]           rsp_outcome,
   // sector size register
   input  wire logic                               csr_write_enable,
   input  wire logic [sesp_pkg::PageBytesW-1:0]    csr_write_data
);

   // byte index only needs to reach the largest usable sector size
   localparam int CapBytes = (MAX_PAGE_BYTES < sesp_pkg::PageBytesCap) ?
                             MAX_PAGE_BYTES : sesp_pkg::PageBytesCap;
   localparam int IdxW = $clog2(CapBytes + 1);

   sesp_pkg::item_type   req_item;
   sesp_pkg::item_type   item;
   logic                 item_valid;
   logic                 advance;
   logic                 can_load;
   sesp_pkg::result_type step_result;
   sesp_pkg::result_type rsp_result;

   // sequencer registers
   sesp_pkg::state_type  state_ff;
   sesp_pkg::state_type  state_in;
   logic [IdxW-1:0]      byte_index_ff;
   logic [IdxW-1:0]      byte_index_in;
   logic [sesp_pkg::PageBytesW-1:0] page_bytes_ff;

   assign req_item.op            = req_op;
   assign req_item.sector_offset = req_sector_offset;
   assign req_item.source_base   = req_source_base;
   assign req_item.response_byte = req_response_byte;
   assign req_item.response_ok   = req_response_ok;

   // a held beat moves on whenever the result register has room
   assign advance = item_valid & can_load;

   sesp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sesp_step #(
      .MAX_PAGE_BYTES (MAX_PAGE_BYTES),
      .IDX_W          (IdxW)
   ) u_step (
      .item            (item),
      .st              (state_ff),
      .byte_index      (byte_index_ff),
      .page_bytes      (page_bytes_ff),
      .st_next         (state_in),
      .byte_index_next (byte_index_in),
      .result          (step_result)
   );

   // sequencer state only moves when a beat goes through the step logic
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sesp_pkg::StateReset;
         byte_index_ff <= '0;
      end else if (advance) begin
         state_ff      <= state_in;
         byte_index_ff <= byte_index_in;
      end
   end

   // sector size register, write only
   always_ff @(posedge clock) begin
      if (reset) begin
         page_bytes_ff <= sesp_pkg::PageBytesReset;
      end else if (csr_write_enable) begin
         page_bytes_ff <= csr_write_data;
      end
   end

   sesp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (step_result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .can_load   (can_load)
   );

   assign rsp_request_kind    = rsp_result.request_kind;
   assign rsp_request_address = rsp_result.request_address;
   assign rsp_write_byte      = rsp_result.write_byte;
   assign rsp_wait_micros     = rsp_result.wait_micros;
   assign rsp_outcome         = rsp_result.outcome;

   // a finished beat always leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      advance && step_result.request_kind == sesp_pkg::KindDone
      |=> state_ff.phase == sesp_pkg::PhIdle)
      else $error("sequencer not idle after finished beat");

   // a start beat always opens with the first unlock read
   assert property (@(posedge clock) disable iff (reset)
      advance && item.op == sesp_pkg::OpStart
      |=> state_ff.phase == sesp_pkg::PhUnprot && state_ff.prefix_step == '0)
      else $error("start beat did not enter unprotect");

   // wait length only on wait beats, outcome only on finished beats
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_kind != sesp_pkg::KindWait |-> rsp_wait_micros == '0)
      else $error("wait length on a non-wait beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_kind != sesp_pkg::KindDone |-> rsp_outcome == '0)
      else $error("outcome on a non-finished beat");

   // lock prefix counter never runs past its table
   assert property (@(posedge clock) disable iff (reset)
      state_ff.prefix_step <= sesp_pkg::PrefixLen)
      else $error("lock prefix step out of range");

endmodule

`default_nettype wire

>>> tb/sv/sector_erase_program_sequencer_top_tb.sv
// sector_erase_program_sequencer_top_tb: self-checking testbench for the
// sequencer, with its own request predictor, a directed table and random traffic.
// Depends on sesp_pkg and sector_erase_program_sequencer_top.
`timescale 1ns / 1ps

module sector_erase_program_sequencer_top_tb;

   localparam int MAX_SECTOR     = sesp_pkg::MaxPageBytesDefault;
   localparam int DRAIN_CYCLES   = 6;     // pipeline is two registers deep, keep some margin
   localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted beat

   // how the sender answers the sequencer's requests
   typedef enum logic [1:0] {
      TrafficNoisy,       // random failures, restarts, bad status bytes
      TrafficClean,       // every access succeeds, every poll passes
      TrafficEraseStuck,  // erase status never ready, runs the poll budget dry
      TrafficProgStuck    // program status never matches, runs out of attempts
   } traffic_type;

   // one directed beat plus, where obvious, the request it must produce
   typedef struct packed {
      sesp_pkg::item_type   beat;
      logic                 typed;
      sesp_pkg::result_type want;
   } stim_row_type;

   // one stretch of random traffic under one sector size
   typedef struct packed {
      logic [sesp_pkg::PageBytesW-1:0] size;
      int                              beats;
      traffic_type                     mode;
   } plan_step_type;

   localparam int NUM_DIRECTED = 23;
   localparam stim_row_type DIRECTED_BEATS [NUM_DIRECTED] = '{
      // response while idle: finished with program error, stays idle
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindDone, 32'h0000_0000, 8'h00, 7'd0, sesp_pkg::OutProgram}},
      // start near the top of the address space
      '{'{sesp_pkg::OpStart, 32'hFFFF_FFC0, 32'hFFFF_FFFF, 8'hFF, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_1823, 8'h00, 7'd0, sesp_pkg::OutOk}},
      // rest of the unprotect reads
      '{'{sesp_pkg::OpResponse, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_1820, 8'h00, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_1822, 8'h00, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_0418, 8'h00, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_041B, 8'h00, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_0419, 8'h00, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_041A, 8'h00, 7'd0, sesp_pkg::OutOk}},
      // erase setup, then confirm at the sector offset
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindWrite, 32'h0000_0000, 8'h20, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindWrite, 32'hFFFF_FFC0, 8'hD0, 7'd0, sesp_pkg::OutOk}},
      // status offset wraps past the top of the address space
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_003F, 8'h00, 7'd0, sesp_pkg::OutOk}},
      // busy status, wait, poll again, then ready
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b0, '0},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b0, '0},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h80, 1'b1}, 1'b0, '0},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1}, 1'b0, '0},
      // blank check: first byte blank, second not
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'hFF, 1'b1}, 1'b0, '0},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'hFE, 1'b1}, 1'b1,
        '{sesp_pkg::KindWrite, 32'h0000_0000, 8'hFF, 7'd0, sesp_pkg::OutOk}},
      // reset write response ignored even when failed
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_1823, 8'h00, 7'd0, sesp_pkg::OutOk}},
      // protect read fails: finished at once with program error
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0}, 1'b1,
        '{sesp_pkg::KindDone, 32'h0000_0000, 8'h00, 7'd0, sesp_pkg::OutProgram}},
      // unprotect read fails: finished at once, no protect reads
      '{'{sesp_pkg::OpStart, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_1823, 8'h00, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpResponse, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0}, 1'b1,
        '{sesp_pkg::KindDone, 32'h0000_0000, 8'h00, 7'd0, sesp_pkg::OutProgram}},
      // start while busy abandons the running job
      '{'{sesp_pkg::OpStart, 32'h1234_5678, 32'h0000_0000, 8'h00, 1'b1}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_1823, 8'h00, 7'd0, sesp_pkg::OutOk}},
      '{'{sesp_pkg::OpStart, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0}, 1'b1,
        '{sesp_pkg::KindRead, 32'h0000_1823, 8'h00, 7'd0, sesp_pkg::OutOk}}
   };

   // sector sizes walked by the random part; the first keeps the reset value
   localparam int NUM_PLAN = 7;
   localparam plan_step_type TRAFFIC_PLAN [NUM_PLAN] = '{
      '{13'd128,  150, TrafficNoisy},
      '{13'd1,    80,  TrafficNoisy},
      '{13'd0,    60,  TrafficNoisy},
      '{13'd3,    100, TrafficNoisy},
      '{13'h1FFF, 60,  TrafficClean},       // clamped to the maximum
      '{13'd1,    540, TrafficProgStuck},   // four failed program attempts
      '{13'd5,    150, TrafficNoisy}
   };

   localparam logic [sesp_pkg::AddrW-1:0] LOCK_ADDRS [6] = '{
      32'h0000_1823, 32'h0000_1820, 32'h0000_1822,
      32'h0000_0418, 32'h0000_041B, 32'h0000_0419
   };

   // clock, reset and block inputs, all known from time zero
   logic                            clock             = 1'b0;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic                            req_op            = sesp_pkg::OpResponse;
   logic [sesp_pkg::AddrW-1:0]      req_sector_offset = '0;
   logic [sesp_pkg::AddrW-1:0]      req_source_base   = '0;
   logic [sesp_pkg::ByteW-1:0]      req_response_byte = '0;
   logic                            req_response_ok   = 1'b0;
   logic                            rsp_stall         = 1'b0;
   logic                            csr_write_enable  = 1'b0;
   logic [sesp_pkg::PageBytesW-1:0] csr_write_data    = '0;

   logic                            req_stall;
   logic                            rsp_valid;
   logic [sesp_pkg::KindW-1:0]      rsp_request_kind;
   logic [sesp_pkg::AddrW-1:0]      rsp_request_address;
   logic [sesp_pkg::ByteW-1:0]      rsp_write_byte;
   logic [sesp_pkg::WaitW-1:0]      rsp_wait_micros;
   logic [sesp_pkg::OutcomeW-1:0]   rsp_outcome;

   // predicted sequencer state, mirrors the block after reset
   logic [sesp_pkg::PhaseW-1:0]     seq_phase     = sesp_pkg::PhIdle;
   logic [sesp_pkg::PageBytesW-1:0] byte_idx      = '0;
   logic [sesp_pkg::AttemptW-1:0]   attempts      = '0;
   logic [sesp_pkg::PollW-1:0]      polls_left    = '0;
   logic [sesp_pkg::PrefixW-1:0]    lock_step     = '0;
   logic [sesp_pkg::ByteW-1:0]      prog_data     = '0;
   logic [sesp_pkg::AddrW-1:0]      sector_addr   = '0;
   logic [sesp_pkg::AddrW-1:0]      source_addr   = '0;
   logic [sesp_pkg::OutcomeW-1:0]   saved_outcome = sesp_pkg::OutOk;
   logic [sesp_pkg::PageBytesW-1:0] sector_size   = sesp_pkg::PageBytesReset;

   // requests still owed by the block, oldest first
   sesp_pkg::result_type expected_requests[$];

   int  mismatches    = 0;
   int  beats_sent    = 0;
   int  beats_checked = 0;
   int  idle_cycles   = 0;
   logic hold_on      = 1'b0;

   sector_erase_program_sequencer_top #(
      .MAX_PAGE_BYTES(MAX_SECTOR)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_sector_offset  (req_sector_offset),
      .req_source_base    (req_source_base),
      .req_response_byte  (req_response_byte),
      .req_response_ok    (req_response_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_request_kind   (rsp_request_kind),
      .rsp_request_address(rsp_request_address),
      .rsp_write_byte     (rsp_write_byte),
      .rsp_wait_micros    (rsp_wait_micros),
      .rsp_outcome        (rsp_outcome),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // request predictor
   // -------------------------------------------------------------------------

   // sizes above the maximum are clamped
   function automatic logic [sesp_pkg::PageBytesW-1:0] usable_bytes();
      return (sector_size > MAX_SECTOR) ? sesp_pkg::PageBytesW'(MAX_SECTOR)
                                        : sector_size;
   endfunction

   // unlock / lock read for the current step, last address after the fixed six
   function automatic sesp_pkg::result_type lock_read_req(
         input logic [sesp_pkg::AddrW-1:0] last);
      return '{sesp_pkg::KindRead,
               (lock_step < sesp_pkg::PrefixLen) ? LOCK_ADDRS[lock_step] : last,
               '0, '0, sesp_pkg::OutOk};
   endfunction

   function automatic sesp_pkg::result_type finished_req(
         input logic [sesp_pkg::OutcomeW-1:0] oc);
      seq_phase = sesp_pkg::PhIdle;
      return '{sesp_pkg::KindDone, '0, '0, '0, oc};
   endfunction

   function automatic sesp_pkg::result_type begin_protect(
         input logic [sesp_pkg::OutcomeW-1:0] oc);
      saved_outcome = oc;
      lock_step     = '0;
      seq_phase     = sesp_pkg::PhProtect;
      return lock_read_req(sesp_pkg::LockLast);
   endfunction

   function automatic sesp_pkg::result_type begin_reset_write(
         input logic [sesp_pkg::OutcomeW-1:0] oc);
      saved_outcome = oc;
      seq_phase     = sesp_pkg::PhResetWrite;
      return '{sesp_pkg::KindWrite, '0, sesp_pkg::CmdReset, '0, sesp_pkg::OutOk};
   endfunction

   function automatic sesp_pkg::result_type program_cmd_req();
      seq_phase = sesp_pkg::PhProgCmd;
      return '{sesp_pkg::KindWrite, '0, sesp_pkg::CmdProgram, '0, sesp_pkg::OutOk};
   endfunction

   // next source byte, or protect with success once the sector is done
   function automatic sesp_pkg::result_type fetch_or_protect();
      if (byte_idx >= usable_bytes())
         return begin_protect(sesp_pkg::OutOk);
      seq_phase = sesp_pkg::PhFetch;
      return '{sesp_pkg::KindFetch, source_addr + sesp_pkg::AddrW'(byte_idx),
               '0, '0, sesp_pkg::OutOk};
   endfunction

   // request produced by one accepted beat, updates the predicted state
   function automatic sesp_pkg::result_type next_request(input sesp_pkg::item_type beat);
      logic [sesp_pkg::AddrW-1:0] here;
      logic [sesp_pkg::ByteW-1:0] rb;
      logic                       ok;
      rb = beat.response_byte;
      ok = beat.response_ok;
      if (beat.op == sesp_pkg::OpStart) begin
         sector_addr   = beat.sector_offset;
         source_addr   = beat.source_base;
         byte_idx      = '0;
         attempts      = '0;
         polls_left    = '0;
         prog_data     = '0;
         saved_outcome = sesp_pkg::OutOk;
         lock_step     = '0;
         seq_phase     = sesp_pkg::PhUnprot;
         return lock_read_req(sesp_pkg::UnlockLast);
      end
      here = sector_addr + sesp_pkg::AddrW'(byte_idx);
      case (seq_phase)
         sesp_pkg::PhUnprot: begin
            if (!ok)
               return finished_req(sesp_pkg::OutProgram);
            if (lock_step < sesp_pkg::PrefixLen) begin
               lock_step = lock_step + 1'b1;
               return lock_read_req(sesp_pkg::UnlockLast);
            end
            seq_phase = sesp_pkg::PhEraseCmd1;
            return '{sesp_pkg::KindWrite, '0, sesp_pkg::CmdEraseSetup, '0,
                     sesp_pkg::OutOk};
         end
         sesp_pkg::PhEraseCmd1: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutErase);
            seq_phase = sesp_pkg::PhEraseCmd2;
            return '{sesp_pkg::KindWrite, sector_addr, sesp_pkg::CmdEraseConfirm, '0,
                     sesp_pkg::OutOk};
         end
         sesp_pkg::PhEraseCmd2: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutErase);
            polls_left = sesp_pkg::ErasePolls;
            seq_phase  = sesp_pkg::PhEraseRead;
            return '{sesp_pkg::KindRead, sector_addr + sesp_pkg::StatusOffset, '0, '0,
                     sesp_pkg::OutOk};
         end
         sesp_pkg::PhEraseRead: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutErase);
            if (polls_left > 0)
               polls_left = polls_left - 1'b1;
            // bit 7 ready, bit 5 timeout
            if (!rb[7] && !rb[5] && polls_left > 0)
               seq_phase = sesp_pkg::PhEraseWaitMore;
            else if (rb[7] && !rb[5])
               seq_phase = sesp_pkg::PhEraseWaitPass;
            else
               seq_phase = sesp_pkg::PhEraseWaitFail;
            return '{sesp_pkg::KindWait, '0, '0, sesp_pkg::EraseWaitUs, sesp_pkg::OutOk};
         end
         sesp_pkg::PhEraseWaitMore, sesp_pkg::PhEraseWaitPass,
         sesp_pkg::PhEraseWaitFail: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutErase);
            if (seq_phase == sesp_pkg::PhEraseWaitMore) begin
               seq_phase = sesp_pkg::PhEraseRead;
               return '{sesp_pkg::KindRead, sector_addr + sesp_pkg::StatusOffset, '0, '0,
                        sesp_pkg::OutOk};
            end
            if (seq_phase == sesp_pkg::PhEraseWaitFail)
               return begin_reset_write(sesp_pkg::OutErase);
            byte_idx = '0;
            if (usable_bytes() == 0)
               return begin_protect(sesp_pkg::OutOk);
            seq_phase = sesp_pkg::PhBlankRead;
            return '{sesp_pkg::KindRead, sector_addr, '0, '0, sesp_pkg::OutOk};
         end
         sesp_pkg::PhBlankRead: begin
            if (!ok || rb != sesp_pkg::BlankByte)
               return begin_reset_write(sesp_pkg::OutErase);
            byte_idx = byte_idx + 1'b1;
            if (byte_idx < usable_bytes())
               return '{sesp_pkg::KindRead, sector_addr + sesp_pkg::AddrW'(byte_idx),
                        '0, '0, sesp_pkg::OutOk};
            byte_idx = '0;
            return fetch_or_protect();
         end
         sesp_pkg::PhFetch: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutProgram);
            prog_data = rb;
            attempts  = '0;
            return program_cmd_req();
         end
         sesp_pkg::PhProgCmd: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutProgram);
            seq_phase = sesp_pkg::PhProgData;
            return '{sesp_pkg::KindWrite, here, prog_data, '0, sesp_pkg::OutOk};
         end
         sesp_pkg::PhProgData: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutProgram);
            polls_left = sesp_pkg::ProgPolls;
            seq_phase  = sesp_pkg::PhProgRead;
            return '{sesp_pkg::KindRead, here, '0, '0, sesp_pkg::OutOk};
         end
         sesp_pkg::PhProgRead: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutProgram);
            if (polls_left > 0)
               polls_left = polls_left - 1'b1;
            // data polling: bit 7 follows the data once done, bit 5 flags a timeout
            if (rb[7] != prog_data[7] && !rb[5] && polls_left > 0)
               seq_phase = sesp_pkg::PhProgWaitMore;
            else
               seq_phase = sesp_pkg::PhProgWaitDone;
            return '{sesp_pkg::KindWait, '0, '0, sesp_pkg::ProgWaitUs, sesp_pkg::OutOk};
         end
         sesp_pkg::PhProgWaitMore, sesp_pkg::PhProgWaitDone: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutProgram);
            seq_phase = (seq_phase == sesp_pkg::PhProgWaitMore) ?
                        sesp_pkg::PhProgRead : sesp_pkg::PhProgCheck;
            return '{sesp_pkg::KindRead, here, '0, '0, sesp_pkg::OutOk};
         end
         sesp_pkg::PhProgCheck: begin
            if (!ok)
               return begin_protect(sesp_pkg::OutProgram);
            if (rb[7] == prog_data[7] && !rb[5]) begin
               byte_idx = byte_idx + 1'b1;
               return fetch_or_protect();
            end
            attempts = attempts + 1'b1;
            if (attempts >= sesp_pkg::MaxAttempts)
               return begin_reset_write(sesp_pkg::OutProgram);
            return program_cmd_req();
         end
         sesp_pkg::PhResetWrite:
            return begin_protect(saved_outcome);
         sesp_pkg::PhProtect: begin
            if (!ok)
               return finished_req(sesp_pkg::OutProgram);
            if (lock_step < sesp_pkg::PrefixLen) begin
               lock_step = lock_step + 1'b1;
               return lock_read_req(sesp_pkg::LockLast);
            end
            return finished_req(saved_outcome);
         end
         default:
            return finished_req(sesp_pkg::OutProgram);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------

   // answer the last request, mostly in a way that moves the job forward
   function automatic sesp_pkg::item_type pick_item(input traffic_type mode);
      sesp_pkg::item_type         beat;
      logic [sesp_pkg::ByteW-1:0] rnd;
      logic                       bit7;
      logic                       noisy;
      int                         roll;
      noisy = (mode == TrafficNoisy);
      rnd   = sesp_pkg::ByteW'($urandom);
      bit7  = prog_data[7];
      roll  = $urandom_range(0, 99);
      beat.op            = sesp_pkg::OpResponse;
      beat.sector_offset = $urandom;
      beat.source_base   = $urandom;
      beat.response_byte = sesp_pkg::ByteW'($urandom);
      beat.response_ok   = noisy ? ($urandom_range(0, 99) >= 3) : 1'b1;
      // idle: mostly a new job, sometimes a stray response
      if (seq_phase == sesp_pkg::PhIdle)
         beat.op = (noisy && roll < 10) ? sesp_pkg::OpResponse : sesp_pkg::OpStart;
      else if (noisy && $urandom_range(0, 199) == 0)
         beat.op = sesp_pkg::OpStart;
      // addresses close to the top so offsets wrap
      if (beat.op == sesp_pkg::OpStart && $urandom_range(0, 3) == 0) begin
         beat.sector_offset[sesp_pkg::AddrW-1:8] = '1;
         beat.source_base[sesp_pkg::AddrW-1:8]   = '1;
      end
      case (seq_phase)
         sesp_pkg::PhEraseRead: begin
            if (mode == TrafficEraseStuck || (noisy && roll < 60))
               beat.response_byte = {1'b0, rnd[6], 1'b0, rnd[4:0]};
            else if (noisy && roll >= 90)
               beat.response_byte = rnd | 8'h20;
            else
               beat.response_byte = {1'b1, rnd[6], 1'b0, rnd[4:0]};
         end
         sesp_pkg::PhBlankRead:
            beat.response_byte = (noisy && roll < 2) ? rnd : sesp_pkg::BlankByte;
         sesp_pkg::PhProgRead: begin
            if (mode == TrafficProgStuck || (noisy && roll >= 50 && roll < 90))
               beat.response_byte = {~bit7, rnd[6], 1'b0, rnd[4:0]};
            else if (noisy && roll >= 90)
               beat.response_byte = rnd | 8'h20;
            else
               beat.response_byte = {bit7, rnd[6], 1'b0, rnd[4:0]};
         end
         sesp_pkg::PhProgCheck: begin
            if (mode == TrafficProgStuck)
               beat.response_byte = {~bit7, rnd[6], 1'b0, rnd[4:0]};
            else if (noisy && roll < 20)
               beat.response_byte = rnd;
            else
               beat.response_byte = {bit7, rnd[6], 1'b0, rnd[4:0]};
         end
         default: ;
      endcase
      return beat;
   endfunction

   // offer one beat after random idle cycles, return at the edge that takes it
   task automatic drive_beat(input sesp_pkg::item_type beat);
      // no sender idling while a stretch of beats goes through
      while (!(beats_sent >= 400 && beats_sent < 700) && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= beat.op;
      req_sector_offset <= beat.sector_offset;
      req_source_base   <= beat.source_base;
      req_response_byte <= beat.response_byte;
      req_response_ok   <= beat.response_ok;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
   endtask

   // main sequence: reset, directed table, then random traffic per sector size
   initial begin
      sesp_pkg::item_type   beat;
      sesp_pkg::result_type predicted;
      int                   n;
      int                   p;

      // reset held at the start, then never again
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed beats, typed expectations where obvious, predictor otherwise
      for (n = 0; n < NUM_DIRECTED; n++) begin
         drive_beat(DIRECTED_BEATS[n].beat);
         predicted = next_request(DIRECTED_BEATS[n].beat);
         expected_requests.push_back(DIRECTED_BEATS[n].typed ? DIRECTED_BEATS[n].want
                                                             : predicted);
      end

      for (p = 0; p < NUM_PLAN; p++) begin
         // size changes only with the pipe empty; this is also the sender's full pause
         if (p != 0) begin
            req_valid <= 1'b0;
            while (expected_requests.size() != 0)
               @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
            csr_write_enable <= 1'b1;
            csr_write_data   <= TRAFFIC_PLAN[p].size;
            @(posedge clock);
            csr_write_enable <= 1'b0;
            sector_size = TRAFFIC_PLAN[p].size;
         end
         for (n = 0; n < TRAFFIC_PLAN[p].beats; n++) begin
            beat = pick_item(TRAFFIC_PLAN[p].mode);
            // each stretch opens with a fresh job, abandoning any running one
            if (n == 0)
               beat.op = sesp_pkg::OpStart;
            drive_beat(beat);
            expected_requests.push_back(next_request(beat));
         end
      end

      // all beats in: wait for every request, then watch for strays
      req_valid <= 1'b0;
      while (expected_requests.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // result side
   // -------------------------------------------------------------------------

   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] seen);
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, seen);
      mismatches++;
   endtask

   // check each accepted result beat against the oldest expectation, then pick the stall
   always @(posedge clock) begin
      sesp_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_requests.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, kind %0h address %0h",
                        $time, rsp_request_kind, rsp_request_address);
               mismatches++;
            end else begin
               want = expected_requests.pop_front();
               if (rsp_request_kind !== want.request_kind)
                  flag_field("request_kind", want.request_kind, rsp_request_kind);
               if (rsp_request_address !== want.request_address)
                  flag_field("request_address", want.request_address, rsp_request_address);
               if (rsp_write_byte !== want.write_byte)
                  flag_field("write_byte", want.write_byte, rsp_write_byte);
               if (rsp_wait_micros !== want.wait_micros)
                  flag_field("wait_micros", want.wait_micros, rsp_wait_micros);
               if (rsp_outcome !== want.outcome)
                  flag_field("outcome", want.outcome, rsp_outcome);
            end
            beats_checked++;
         end
         // random stalls, none in one long stretch, solid during the hold-off
         rsp_stall <= hold_on ||
                      (!(beats_checked >= 750 && beats_checked < 1050) &&
                       $urandom_range(0, 99) < 37);
      end
   end

   // one long hold-off early on so the block fills and stalls its input
   initial begin
      wait (beats_checked >= 150);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // watchdog: too long without any beat moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
